// File: design/iee_pkg.sv
// shared types, character codes and constants of the infix expression evaluator
// no dependencies; imported by iee_arith and infix_expression_evaluator_unit
package iee_pkg;

   localparam int VALUE_WIDTH     = 64;
   localparam int RESULT_WIDTH    = 64;
   localparam int ADD_WIDTH       = VALUE_WIDTH + 2;
   localparam int CNT_WIDTH       = $clog2(VALUE_WIDTH);
   localparam int RSP_TDATA_WIDTH = ((RESULT_WIDTH + 2 + 7) / 8) * 8;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BADCHAR = 2'd1,
      ST_SYNTAX  = 2'd2,
      ST_DIVZERO = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PD_NONE = 2'd0,
      PD_MUL  = 2'd1,
      PD_DIV  = 2'd2
   } pend_type;

   typedef enum logic [1:0] {
      TK_NONE = 2'd0,
      TK_NUM  = 2'd1,
      TK_OP   = 2'd2
   } token_type;

   typedef enum logic [2:0] {
      CK_TERM,
      CK_DIGIT,
      CK_OP,
      CK_SPACE,
      CK_BAD
   } char_kind_type;

   typedef enum logic {
      AO_MUL,
      AO_DIV
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_req_type;

   typedef enum logic [2:0] {
      AU_IDLE,
      AU_NEG_A,
      AU_NEG_B,
      AU_LOOP,
      AU_FIX,
      AU_DONE
   } arith_state_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_DECODE,
      CS_CLOSE,
      CS_WAIT,
      CS_FINISH,
      CS_EMIT
   } ctl_state_type;

   function automatic char_kind_type classify(input logic [7:0] c, input logic eos);
      char_kind_type k;
      if (eos || c == CH_NEWLINE || c == CH_NUL) begin
         k = CK_TERM;
      end else if (c inside {[CH_ZERO:CH_NINE]}) begin
         k = CK_DIGIT;
      end else if (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}) begin
         k = CK_OP;
      end else if (c == CH_SPACE || c inside {[CH_TAB:CH_CR]}) begin
         k = CK_SPACE;
      end else begin
         k = CK_BAD;
      end
      return k;
   endfunction

endpackage

// File: design/iee_arith.sv
// shared iterative arithmetic unit: shift-add multiply and restoring divide
// one adder serves operand negation, partial sums and trial subtraction; uses iee_pkg
module iee_arith (
   input  logic                  clock,
   input  logic                  reset,
   input  iee_pkg::arith_req_type req,
   input  iee_pkg::value_type    a,
   input  iee_pkg::value_type    b,
   output logic                  done,
   output iee_pkg::value_type    result
);
   import iee_pkg::*;

   arith_state_type          state_ff, state_in;
   arith_op_type             op_ff, op_in;
   logic                     neg_ff, neg_in;
   logic [CNT_WIDTH-1:0]     cnt_ff, cnt_in;
   value_type                opx_ff, opx_in;   // multiplicand / divisor
   value_type                opy_ff, opy_in;   // multiplier / dividend then quotient
   value_type                acc_ff, acc_in;   // product / remainder

   logic [ADD_WIDTH-1:0]     add_x, add_y, add_sum;
   logic                     add_sub;
   logic                     fits;

   // the one adder
   assign add_sum = add_x + (add_sub ? ~add_y : add_y) + ADD_WIDTH'(add_sub);
   assign fits    = ~add_sum[ADD_WIDTH-1];

   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         AU_IDLE: begin
            if (req.start) begin
               state_in = (req.op == AO_MUL) ? AU_LOOP : AU_NEG_A;
            end
         end
         AU_NEG_A: state_in = AU_NEG_B;
         AU_NEG_B: state_in = AU_LOOP;
         AU_LOOP: begin
            if (cnt_ff == '0) begin
               state_in = (op_ff == AO_MUL) ? AU_DONE : AU_FIX;
            end
         end
         AU_FIX:  state_in = AU_DONE;
         AU_DONE: state_in = AU_IDLE;
         default: state_in = AU_IDLE;
      endcase
   end

   always_comb begin : adder_operands
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b0;
      case (state_ff)
         AU_NEG_A: begin
            add_y   = ADD_WIDTH'(opy_ff);
            add_sub = 1'b1;
         end
         AU_NEG_B: begin
            add_y   = ADD_WIDTH'(opx_ff);
            add_sub = 1'b1;
         end
         AU_LOOP: begin
            if (op_ff == AO_MUL) begin
               add_x = ADD_WIDTH'(acc_ff);
               add_y = ADD_WIDTH'(opx_ff);
            end else begin
               add_x   = ADD_WIDTH'({acc_ff, opy_ff[VALUE_WIDTH-1]});
               add_y   = ADD_WIDTH'(opx_ff);
               add_sub = 1'b1;
            end
         end
         AU_FIX: begin
            add_y   = ADD_WIDTH'(opy_ff);
            add_sub = 1'b1;
         end
         default: begin
            add_sub = 1'b0;
         end
      endcase
   end

   always_comb begin : datapath
      op_in  = op_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      opx_in = opx_ff;
      opy_in = opy_ff;
      acc_in = acc_ff;
      case (state_ff)
         AU_IDLE: begin
            if (req.start) begin
               op_in  = req.op;
               neg_in = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
               cnt_in = CNT_WIDTH'(VALUE_WIDTH - 1);
               opx_in = b;
               opy_in = a;
               acc_in = '0;
            end
         end
         AU_NEG_A: begin
            if (opy_ff[VALUE_WIDTH-1]) begin
               opy_in = add_sum[VALUE_WIDTH-1:0];
            end
         end
         AU_NEG_B: begin
            if (opx_ff[VALUE_WIDTH-1]) begin
               opx_in = add_sum[VALUE_WIDTH-1:0];
            end
         end
         AU_LOOP: begin
            cnt_in = cnt_ff - CNT_WIDTH'(1);
            if (op_ff == AO_MUL) begin
               if (opy_ff[0]) begin
                  acc_in = add_sum[VALUE_WIDTH-1:0];
               end
               opx_in = {opx_ff[VALUE_WIDTH-2:0], 1'b0};
               opy_in = {1'b0, opy_ff[VALUE_WIDTH-1:1]};
            end else begin
               acc_in = fits ? add_sum[VALUE_WIDTH-1:0]
                             : {acc_ff[VALUE_WIDTH-2:0], opy_ff[VALUE_WIDTH-1]};
               opy_in = {opy_ff[VALUE_WIDTH-2:0], fits};
            end
         end
         AU_FIX: begin
            if (neg_ff) begin
               opy_in = add_sum[VALUE_WIDTH-1:0];
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AU_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff  <= op_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      opx_ff <= opx_in;
      opy_ff <= opy_in;
      acc_ff <= acc_in;
   end

   assign done   = (state_ff == AU_DONE);
   assign result = (op_ff == AO_MUL) ? acc_ff : opy_ff;

   // a start only lands on an idle unit
   assert property (@(posedge clock) disable iff (reset)
      req.start |-> state_ff == AU_IDLE)
      else $error("arith start while busy");

   // done lasts exactly one cycle
   assert property (@(posedge clock) disable iff (reset)
      state_ff == AU_DONE |=> state_ff == AU_IDLE)
      else $error("arith done held");

   // multiply leaves the loop straight to done, divide goes through sign fix
   assert property (@(posedge clock) disable iff (reset)
      state_ff == AU_LOOP && cnt_ff == '0 && op_ff == AO_DIV |=> state_ff == AU_FIX)
      else $error("divide skipped sign fix");

endmodule

// File: design/infix_expression_evaluator_unit.sv
// top level of the infix expression evaluator: stream ports, token sequencer, result register
// depends on iee_pkg and iee_arith
//
// The block reads one ASCII character per input word and evaluates an infix expression of
// unsigned decimal integers joined by + - * /, with * and / binding tighter than + and -,
// both levels left to right, in wrapping two's complement arithmetic of VALUE_WIDTH bits with
// truncating division. Whitespace (tab, vertical tab, form feed, carriage return, space)
// separates tokens. A newline, a NUL or a word with req_tlast set ends the expression and
// produces one result word: the value sign-extended to 64 bits and a status (0 ok,
// 1 bad character, 2 syntax error, 3 divide by zero; the value is zero unless ok). After an
// error the rest of the expression is skipped and the first error is reported. Every other
// input word produces no result. req_tready is high only while the sequencer is idle: a
// digit is decoded and done, whitespace or an operator goes on through close and finish, and
// a character that closes a number after * or after / with a nonzero divisor waits in between
// for the shared iterative multiply/divide unit; that one unit, one result bit per cycle, sets
// the rate. A terminator also passes through an emit state and waits there while an earlier
// result still sits unread on the rsp side; other characters are taken while a result waits.
module infix_expression_evaluator_unit (
   input  logic                                clock,
   input  logic                                reset,
   // input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] char_code
   input  logic                                req_tlast,   // end_of_stream
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [iee_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata    // [63:0] result_value,
                                                            // [65:64] status, rest zero
);
   import iee_pkg::*;

   // sequencer
   ctl_state_type             state_ff, state_in;
   // registered input word
   logic [7:0]                char_ff, char_in;
   char_kind_type             kind_ff, kind_in;
   // expression state
   value_type                 sum_ff, sum_in;
   value_type                 term_ff, term_in;
   value_type                 num_ff, num_in;
   logic                      sign_ff, sign_in;
   pend_type                  pend_ff, pend_in;
   token_type                 last_ff, last_in;
   logic                      open_ff, open_in;
   status_type                err_ff, err_in;
   // pending result, filled when a terminator finishes
   logic [RESULT_WIDTH-1:0]   res_value_ff, res_value_in;
   status_type                res_status_ff, res_status_in;
   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RESULT_WIDTH-1:0]   rsp_value_ff, rsp_value_in;
   status_type                rsp_status_ff, rsp_status_in;

   arith_req_type             arith_req;
   logic                      arith_done;
   value_type                 arith_result;

   logic                      accept;
   logic                      rsp_free;
   logic [3:0]                digit;
   value_type                 num_next;
   value_type                 fold;
   status_type                err_final;

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign digit    = 4'(char_ff - CH_ZERO);
   // number times ten plus the new digit
   assign num_next = (num_ff << 3) + (num_ff << 1) + VALUE_WIDTH'(digit);
   // fold the current term into the running sum
   assign fold     = sign_ff ? (sum_ff - term_ff) : (sum_ff + term_ff);
   // error reported by a terminator: first error, else a missing final number
   assign err_final = (err_ff != ST_OK) ? err_ff : ((last_ff != TK_NUM) ? ST_SYNTAX : ST_OK);

   iee_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .req    (arith_req),
      .a      (term_ff),
      .b      (num_ff),
      .done   (arith_done),
      .result (arith_result)
   );

   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (accept) begin
               state_in = CS_DECODE;
            end
         end
         CS_DECODE: begin
            case (kind_ff)
               CK_TERM:  state_in = (err_ff == ST_OK) ? CS_CLOSE : CS_FINISH;
               CK_OP,
               CK_SPACE: state_in = (err_ff == ST_OK) ? CS_CLOSE : CS_IDLE;
               default:  state_in = CS_IDLE;
            endcase
         end
         CS_CLOSE: begin
            if (open_ff && (pend_ff == PD_MUL || (pend_ff == PD_DIV && num_ff != '0))) begin
               state_in = CS_WAIT;
            end else begin
               state_in = CS_FINISH;
            end
         end
         CS_WAIT: begin
            if (arith_done) begin
               state_in = CS_FINISH;
            end
         end
         CS_FINISH: state_in = (kind_ff == CK_TERM) ? CS_EMIT : CS_IDLE;
         CS_EMIT: begin
            if (rsp_free) begin
               state_in = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin : outputs
      req_tready      = (state_ff == CS_IDLE);
      arith_req.start = 1'b0;
      arith_req.op    = AO_MUL;

      char_in       = char_ff;
      kind_in       = kind_ff;
      sum_in        = sum_ff;
      term_in       = term_ff;
      num_in        = num_ff;
      sign_in       = sign_ff;
      pend_in       = pend_ff;
      last_in       = last_ff;
      open_in       = open_ff;
      err_in        = err_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         CS_IDLE: begin
            if (accept) begin
               char_in = req_tdata;
               kind_in = classify(req_tdata, req_tlast);
            end
         end
         CS_DECODE: begin
            // digits and bad characters finish here; with no error the rest go on to close a number
            if (err_ff == ST_OK) begin
               case (kind_ff)
                  CK_DIGIT: begin
                     if (open_ff) begin
                        num_in = num_next;
                     end else if (last_ff == TK_NUM) begin
                        err_in = ST_SYNTAX;
                     end else begin
                        open_in = 1'b1;
                        num_in  = VALUE_WIDTH'(digit);
                        last_in = TK_NUM;
                     end
                  end
                  CK_BAD:  err_in = ST_BADCHAR;
                  default: err_in = err_ff;
               endcase
            end
         end
         CS_CLOSE: begin
            if (open_ff) begin
               case (pend_ff)
                  PD_MUL: begin
                     arith_req.start = 1'b1;
                     arith_req.op    = AO_MUL;
                  end
                  PD_DIV: begin
                     if (num_ff == '0) begin
                        err_in = ST_DIVZERO;
                     end else begin
                        arith_req.start = 1'b1;
                        arith_req.op    = AO_DIV;
                     end
                  end
                  default: term_in = num_ff;
               endcase
               pend_in = PD_NONE;
               open_in = 1'b0;
            end
         end
         CS_WAIT: begin
            if (arith_done) begin
               term_in = arith_result;
            end
         end
         CS_FINISH: begin
            case (kind_ff)
               CK_OP: begin
                  if (err_ff == ST_OK) begin
                     if (last_ff != TK_NUM) begin
                        err_in = ST_SYNTAX;
                     end else begin
                        if (char_ff == CH_PLUS || char_ff == CH_MINUS) begin
                           sum_in  = fold;
                           term_in = '0;
                           sign_in = (char_ff == CH_MINUS);
                           pend_in = PD_NONE;
                        end else begin
                           pend_in = (char_ff == CH_STAR) ? PD_MUL : PD_DIV;
                        end
                        last_in = TK_OP;
                     end
                  end
               end
               CK_TERM: begin
                  res_status_in = err_final;
                  res_value_in  = (err_final == ST_OK) ? RESULT_WIDTH'(signed'(fold)) : '0;
               end
               default: err_in = err_ff;
            endcase
         end
         CS_EMIT: begin
            // hand the result to the output register and start a fresh expression
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               sum_in        = '0;
               term_in       = '0;
               num_in        = '0;
               sign_in       = 1'b0;
               pend_in       = PD_NONE;
               last_in       = TK_NONE;
               open_in       = 1'b0;
               err_in        = ST_OK;
            end
         end
         default: begin
            err_in = err_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         sum_ff       <= '0;
         term_ff      <= '0;
         num_ff       <= '0;
         sign_ff      <= 1'b0;
         pend_ff      <= PD_NONE;
         last_ff      <= TK_NONE;
         open_ff      <= 1'b0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         term_ff      <= term_in;
         num_ff       <= num_in;
         sign_ff      <= sign_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
         open_ff      <= open_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff       <= char_in;
      kind_ff       <= kind_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_WIDTH'({rsp_status_ff, rsp_value_ff});

   // every accepted word is decoded in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == CS_DECODE)
      else $error("accepted word not decoded");

   // the sequencer leaves the wait state as soon as the shared unit finishes
   assert property (@(posedge clock) disable iff (reset)
      state_ff == CS_WAIT && arith_done |=> state_ff == CS_FINISH)
      else $error("unit result dropped");

   // a new result word only comes out of the emit state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == CS_EMIT)
      else $error("result word from wrong state");

   // an error result carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_value_ff == '0)
      else $error("error result with nonzero value");

endmodule
